@@ rtl/core/segtree_pkg.sv @@
// ----------------------------------------------------------------------------
// segtree_pkg
// Shared widths, defaults and the command/status bundles that run between
// the segment tree controller and its datapath.
// ----------------------------------------------------------------------------
package segtree_pkg;

    // payload field widths
    localparam int IDX_W = 10;
    localparam int VAL_W = 32;

    // leaf count: default and upper limit of the supported range
    localparam int LEAVES_DEF = 1024;
    localparam int LEAVES_MAX = 1048576;

    // controller to datapath commands
    typedef struct packed {
        logic load;      // capture an accepted item
        logic clr_step;  // write zero at the clear pointer
        logic upd_leaf;  // write the leaf, fetch its sibling
        logic upd_up;    // write one ancestor sum, fetch the next sibling
        logic walk;      // one iteration of the range walk
        logic out_load;  // move the sum into the result register
    } ctrl_cmd_t;

    // datapath to controller status
    typedef struct packed {
        logic kind_query;  // item on the input port is a query
        logic upd_ok;      // update index lies inside the array
        logic qry_ok;      // query range is non-empty after saturation
        logic walk_more;   // range walk still has nodes to visit
        logic at_top;      // parent of the current node is the root
        logic clr_last;    // clear pointer sits on the last node
        logic out_free;    // result register can take a new sum
    } ctrl_stat_t;

endpackage

@@ rtl/core/segtree_ram.sv @@
// ----------------------------------------------------------------------------
// segtree_ram
// Generic RAM: one write port, two read ports, registered read data.
// ----------------------------------------------------------------------------
module segtree_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 2048
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr_a,
    input  logic [$clog2(DEPTH)-1:0] raddr_b,
    output logic [WIDTH-1:0]         rdata_a,
    output logic [WIDTH-1:0]         rdata_b
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port and registered reads
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_a <= mem[raddr_a];
        rdata_b <= mem[raddr_b];
    end

endmodule

@@ rtl/core/segtree_ctrl.sv @@
// ----------------------------------------------------------------------------
// segtree_ctrl
// Sequencer for the segment tree: clearing pass after reset, update walk
// from leaf to root, range walk for queries and result hand-off.
// ----------------------------------------------------------------------------
module segtree_ctrl (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    s_valid,
    output logic                    s_ready,
    input  segtree_pkg::ctrl_stat_t stat,
    output segtree_pkg::ctrl_cmd_t  cmd
);

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_UPD_LEAF,
        ST_UPD_UP,
        ST_QRY_WALK,
        ST_QRY_OUT
    } state_t;

    state_t state_reg;
    state_t state_next;

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_CLEAR: begin
                if (stat.clr_last) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (s_valid) begin
                    if (stat.kind_query) begin
                        state_next = stat.qry_ok ? ST_QRY_WALK : ST_QRY_OUT;
                    end else if (stat.upd_ok) begin
                        state_next = ST_UPD_LEAF;
                    end
                end
            end
            ST_UPD_LEAF: begin
                state_next = ST_UPD_UP;
            end
            ST_UPD_UP: begin
                if (stat.at_top) begin
                    state_next = ST_IDLE;
                end
            end
            ST_QRY_WALK: begin
                if (!stat.walk_more) begin
                    state_next = ST_QRY_OUT;
                end
            end
            ST_QRY_OUT: begin
                if (stat.out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_CLEAR;
            end
        endcase
    end

    // state register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_CLEAR;
        end else begin
            state_reg <= state_next;
        end
    end

    // command decode
    always_comb begin
        cmd          = '0;
        cmd.clr_step = (state_reg == ST_CLEAR);
        cmd.load     = (state_reg == ST_IDLE) && s_valid;
        cmd.upd_leaf = (state_reg == ST_UPD_LEAF);
        cmd.upd_up   = (state_reg == ST_UPD_UP);
        cmd.walk     = (state_reg == ST_QRY_WALK);
        cmd.out_load = (state_reg == ST_QRY_OUT) && stat.out_free;
    end

    assign s_ready = (state_reg == ST_IDLE);

endmodule

@@ rtl/core/segtree_dp.sv @@
// ----------------------------------------------------------------------------
// segtree_dp
// Datapath for the segment tree: node RAM, walk pointers, accumulator,
// clear pointer and the result register.
// ----------------------------------------------------------------------------
module segtree_dp #(
    parameter int LEAVES = segtree_pkg::LEAVES_DEF
) (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    input  logic                                   s_kind,
    input  logic        [segtree_pkg::IDX_W-1:0]   s_index,
    input  logic signed [segtree_pkg::VAL_W-1:0]   s_value,
    input  logic        [segtree_pkg::IDX_W-1:0]   s_range_low,
    input  logic        [segtree_pkg::IDX_W-1:0]   s_range_high,
    output logic                                   m_valid,
    input  logic                                   m_ready,
    output logic signed [segtree_pkg::VAL_W-1:0]   m_range_sum,
    input  segtree_pkg::ctrl_cmd_t                 cmd,
    output segtree_pkg::ctrl_stat_t                stat
);

    localparam int VAL_W  = segtree_pkg::VAL_W;
    localparam int IDX_W  = segtree_pkg::IDX_W;
    localparam int NODE_W = $clog2(LEAVES) + 1;
    localparam int POS_W  = NODE_W + 1;
    localparam int EXT_W  = ((IDX_W > NODE_W) ? IDX_W : NODE_W) + 1;
    localparam int NODES  = 2 * LEAVES;

    localparam logic [EXT_W-1:0] LEAVES_EXT = EXT_W'(LEAVES);

    // walk registers
    logic [NODE_W-1:0] pos_reg;
    logic [POS_W-1:0]  left_reg;
    logic [POS_W-1:0]  right_reg;
    logic              take_l_reg;
    logic              take_r_reg;
    logic [VAL_W-1:0]  acc_reg;
    logic [NODE_W-1:0] clr_cnt_reg;
    logic              m_valid_reg;
    logic [VAL_W-1:0]  m_range_sum_reg;

    // ram ports
    logic              ram_we;
    logic [NODE_W-1:0] ram_waddr;
    logic [VAL_W-1:0]  ram_wdata;
    logic [NODE_W-1:0] ram_raddr_a;
    logic [NODE_W-1:0] ram_raddr_b;
    logic [VAL_W-1:0]  ram_rdata_a;
    logic [VAL_W-1:0]  ram_rdata_b;

    // input decode
    logic [EXT_W-1:0]  idx_ext;
    logic [EXT_W-1:0]  lo_ext;
    logic [EXT_W-1:0]  hi_ext;
    logic [EXT_W-1:0]  hi_sat;
    logic [EXT_W-1:0]  leaf_ext;
    logic [EXT_W-1:0]  left_ext;
    logic [EXT_W-1:0]  right_ext;

    // walk arithmetic
    logic [NODE_W-1:0] parent;
    logic [NODE_W-1:0] par_sib;
    logic [POS_W-1:0]  left_inc;
    logic [POS_W-1:0]  right_dec;
    logic              walk_more;
    logic [VAL_W-1:0]  up_sum;
    logic [VAL_W-1:0]  add_l;
    logic [VAL_W-1:0]  add_r;

    segtree_ram #(
        .WIDTH (VAL_W),
        .DEPTH (NODES)
    ) u_ram (
        .aclk    (aclk),
        .we      (ram_we),
        .waddr   (ram_waddr),
        .wdata   (ram_wdata),
        .raddr_a (ram_raddr_a),
        .raddr_b (ram_raddr_b),
        .rdata_a (ram_rdata_a),
        .rdata_b (ram_rdata_b)
    );

    // range and index checks on the offered item
    always_comb begin
        idx_ext   = EXT_W'(s_index);
        lo_ext    = EXT_W'(s_range_low);
        hi_ext    = EXT_W'(s_range_high);
        hi_sat    = (hi_ext >= LEAVES_EXT) ? (LEAVES_EXT - EXT_W'(1)) : hi_ext;
        leaf_ext  = LEAVES_EXT + idx_ext;
        left_ext  = LEAVES_EXT + lo_ext;
        right_ext = LEAVES_EXT + hi_sat + EXT_W'(1);
    end

    // tree walk arithmetic
    always_comb begin
        parent    = {1'b0, pos_reg[NODE_W-1:1]};
        par_sib   = {parent[NODE_W-1:1], ~parent[0]};
        left_inc  = left_reg + POS_W'(left_reg[0]);
        right_dec = right_reg - POS_W'(right_reg[0]);
        walk_more = (left_reg < right_reg);
        up_sum    = acc_reg + ram_rdata_a;
        add_l     = take_l_reg ? ram_rdata_a : '0;
        add_r     = take_r_reg ? ram_rdata_b : '0;
    end

    // ram port selection
    always_comb begin
        ram_we      = 1'b0;
        ram_waddr   = clr_cnt_reg;
        ram_wdata   = '0;
        ram_raddr_a = left_reg[NODE_W-1:0];
        ram_raddr_b = right_dec[NODE_W-1:0];
        if (cmd.clr_step) begin
            ram_we = 1'b1;
        end else if (cmd.upd_leaf) begin
            ram_we      = 1'b1;
            ram_waddr   = pos_reg;
            ram_wdata   = acc_reg;
            ram_raddr_a = {pos_reg[NODE_W-1:1], ~pos_reg[0]};
        end else if (cmd.upd_up) begin
            ram_we      = 1'b1;
            ram_waddr   = parent;
            ram_wdata   = up_sum;
            ram_raddr_a = par_sib;
        end
    end

    // walk pointers and accumulator
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            pos_reg    <= leaf_ext[NODE_W-1:0];
            left_reg   <= left_ext[POS_W-1:0];
            right_reg  <= right_ext[POS_W-1:0];
            take_l_reg <= 1'b0;
            take_r_reg <= 1'b0;
            acc_reg    <= s_kind ? '0 : s_value;
        end else if (cmd.upd_up) begin
            pos_reg <= parent;
            acc_reg <= up_sum;
        end else begin
            if (cmd.walk) begin
                left_reg   <= left_inc >> 1;
                right_reg  <= right_dec >> 1;
                take_l_reg <= walk_more & left_reg[0];
                take_r_reg <= walk_more & right_reg[0];
            end else begin
                take_l_reg <= 1'b0;
                take_r_reg <= 1'b0;
            end
            acc_reg <= acc_reg + add_l + add_r;
        end
    end

    // clear pointer
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_cnt_reg <= '0;
        end else if (cmd.clr_step) begin
            clr_cnt_reg <= clr_cnt_reg + NODE_W'(1);
        end
    end

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.out_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            m_range_sum_reg <= acc_reg;
        end
    end

    assign m_valid     = m_valid_reg;
    assign m_range_sum = $signed(m_range_sum_reg);

    // status back to the controller
    always_comb begin
        stat            = '0;
        stat.kind_query = s_kind;
        stat.upd_ok     = (idx_ext < LEAVES_EXT);
        stat.qry_ok     = (lo_ext <= hi_ext) && (lo_ext < LEAVES_EXT);
        stat.walk_more  = walk_more;
        stat.at_top     = (pos_reg[NODE_W-1:1] == (NODE_W-1)'(1));
        stat.clr_last   = (clr_cnt_reg == NODE_W'(NODES - 1));
        stat.out_free   = !m_valid_reg || m_ready;
    end

endmodule

@@ rtl/core/segment_tree_point_update_range_sum_top.sv @@
// ----------------------------------------------------------------------------
// segment_tree_point_update_range_sum_top
// Point-update, range-sum segment tree over LEAVES signed 32-bit elements.
// ----------------------------------------------------------------------------
// After reset the block runs a clearing pass over all 2*LEAVES tree nodes,
// one node per cycle, with s_ready low. Updates (s_kind = 0) write one
// element and produce no result; an index at or above LEAVES is dropped.
// Queries (s_kind = 1) return the wrapped sum of the elements
// range_low..range_high, zero for an inverted range or range_low at or
// above LEAVES, with range_high saturated to LEAVES-1. Both kinds of item
// walk the node RAM one tree level per cycle behind its registered read.
// A finished sum waits in an output register, so the next item is taken
// while it is pending.
module segment_tree_point_update_range_sum_top #(
    parameter int LEAVES = segtree_pkg::LEAVES_DEF
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 s_valid,
    output logic                                 s_ready,
    input  logic                                 s_kind,
    input  logic        [segtree_pkg::IDX_W-1:0] s_index,
    input  logic signed [segtree_pkg::VAL_W-1:0] s_value,
    input  logic        [segtree_pkg::IDX_W-1:0] s_range_low,
    input  logic        [segtree_pkg::IDX_W-1:0] s_range_high,
    output logic                                 m_valid,
    input  logic                                 m_ready,
    output logic signed [segtree_pkg::VAL_W-1:0] m_range_sum
);

    segtree_pkg::ctrl_cmd_t  cmd;
    segtree_pkg::ctrl_stat_t stat;

    // sequencer
    segtree_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .stat    (stat),
        .cmd     (cmd)
    );

    // node store and arithmetic
    segtree_dp #(
        .LEAVES (LEAVES)
    ) u_dp (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_kind       (s_kind),
        .s_index      (s_index),
        .s_value      (s_value),
        .s_range_low  (s_range_low),
        .s_range_high (s_range_high),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_range_sum  (m_range_sum),
        .cmd          (cmd),
        .stat         (stat)
    );

    // clearing pass starts right after reset, no transfer taken
    a_clear_after_reset: assert property (@(posedge aclk)
        !aresetn |=> !s_ready)
        else $error("input accepted during clearing pass");

    // an accepted update never raises a result
    a_update_no_result: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready && !s_kind && !m_valid) |=> !m_valid)
        else $error("update produced a result");

    // an accepted query keeps the block busy for its walk
    a_query_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready && s_kind) |=> !s_ready)
        else $error("query accepted without a busy cycle");

    // a result only appears while the block is busy with a query
    a_result_source: assert property (@(posedge aclk) disable iff (!aresetn)
        (!m_valid && s_ready) |=> (!m_valid || !$past(s_ready)))
        else $error("result raised while idle");

endmodule

@@ tb/segtree_tb_pkg.sv @@
// ----------------------------------------------------------------------------
// segtree_tb_pkg
// Item codes shared by the segment tree stimulus and its result checker.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

package segtree_tb_pkg;

    // what an input transfer asks of the tree
    typedef enum logic {
        ITEM_UPDATE = 1'b0,
        ITEM_QUERY  = 1'b1
    } item_kind_e;

endpackage

@@ tb/segtree_range_sum_checker.sv @@
// ----------------------------------------------------------------------------
// segtree_range_sum_checker
// Watches both channels of the segment tree. Keeps its own copy of the
// element array, works out the wrapped sum for every accepted query and
// compares each result transfer with the oldest pending sum.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module segtree_range_sum_checker #(
    parameter int LEAVES = segtree_pkg::LEAVES_DEF
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 s_valid,
    input  logic                                 s_ready,
    input  logic                                 s_kind,
    input  logic        [segtree_pkg::IDX_W-1:0] s_index,
    input  logic signed [segtree_pkg::VAL_W-1:0] s_value,
    input  logic        [segtree_pkg::IDX_W-1:0] s_range_low,
    input  logic        [segtree_pkg::IDX_W-1:0] s_range_high,
    input  logic                                 m_valid,
    input  logic                                 m_ready,
    input  logic signed [segtree_pkg::VAL_W-1:0] m_range_sum,
    output int                                   fail_count,
    output int                                   pending_count
);

    localparam int VAL_W = segtree_pkg::VAL_W;

    // element values as the tree should hold them
    logic [VAL_W-1:0] elements [LEAVES];

    // sums of accepted queries still waiting for their result transfer
    logic signed [VAL_W-1:0] pending_sums [$];

    // wrapped sum over lo..hi, high end clipped to the array, empty range gives zero
    function automatic logic [VAL_W-1:0] range_total(int unsigned lo, int unsigned hi);
        logic [VAL_W-1:0] acc;
        int unsigned      last_idx;
        acc = '0;
        if (lo > hi || lo >= LEAVES) begin
            return '0;
        end
        last_idx = (hi >= LEAVES) ? LEAVES - 1 : hi;
        for (int unsigned i = lo; i <= last_idx; i++) begin
            acc += elements[i];
        end
        return acc;
    endfunction

    always @(posedge aclk) begin
        logic signed [VAL_W-1:0] want;
        if (!aresetn) begin
            foreach (elements[i]) begin
                elements[i] = '0;
            end
            pending_sums.delete();
        end else begin
            // result transfer against the oldest pending query
            if (m_valid && m_ready) begin
                if (pending_sums.size() == 0) begin
                    $error("range_sum with no query pending: actual %0d", m_range_sum);
                    fail_count++;
                end else begin
                    want = pending_sums.pop_front();
                    if (m_range_sum !== want) begin
                        $error("range_sum mismatch: expected %0d, actual %0d",
                               want, m_range_sum);
                        fail_count++;
                    end
                end
            end
            // input transfer: queries queue a sum, updates write an element
            if (s_valid && s_ready) begin
                if (s_kind == segtree_tb_pkg::ITEM_QUERY) begin
                    pending_sums.push_back(range_total(32'(s_range_low),
                                                       32'(s_range_high)));
                end else if (s_index < LEAVES) begin
                    elements[s_index] = s_value;
                end
            end
        end
        pending_count = pending_sums.size();
    end

endmodule

@@ tb/segment_tree_point_update_range_sum_top_tb.sv @@
// ----------------------------------------------------------------------------
// segment_tree_point_update_range_sum_top_tb
// Drives point updates and range sum queries into the segment tree: a
// directed set over the array ends, wrapping and inverted ranges, then
// random traffic under changing idle patterns and one long result stall.
// Results are checked by segtree_range_sum_checker.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module segment_tree_point_update_range_sum_top_tb;

    localparam int IDX_W        = segtree_pkg::IDX_W;
    localparam int VAL_W        = segtree_pkg::VAL_W;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int HOLD_CYCLES  = 400;
    localparam int DRAIN_CYCLES = 32;

    logic                    aclk = 1'b0;
    logic                    aresetn;
    logic                    s_valid;
    logic                    s_ready;
    logic                    s_kind;
    logic        [IDX_W-1:0] s_index;
    logic signed [VAL_W-1:0] s_value;
    logic        [IDX_W-1:0] s_range_low;
    logic        [IDX_W-1:0] s_range_high;
    logic                    m_valid;
    logic                    m_ready;
    logic signed [VAL_W-1:0] m_range_sum;

    int          fail_count;
    int          pending_count;
    int unsigned src_idle_pct;
    int unsigned dst_idle_pct;
    bit          hold_go;
    int unsigned cycle_cnt = 0;

    segment_tree_point_update_range_sum_top DUT (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_kind       (s_kind),
        .s_index      (s_index),
        .s_value      (s_value),
        .s_range_low  (s_range_low),
        .s_range_high (s_range_high),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_range_sum  (m_range_sum)
    );

    segtree_range_sum_checker u_sum_check (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_kind        (s_kind),
        .s_index       (s_index),
        .s_value       (s_value),
        .s_range_low   (s_range_low),
        .s_range_high  (s_range_high),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_range_sum   (m_range_sum),
        .fail_count    (fail_count),
        .pending_count (pending_count)
    );

    // 10 ns clock
    always #5 aclk = ~aclk;

    // run limit
    always @(posedge aclk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == CYCLE_LIMIT) begin
            $display("FAIL segment_tree_point_update_range_sum_top");
            $finish;
        end
    end

    // result side: random stalls, plus one long hold-off on request
    initial begin
        int unsigned hold_left;
        bit          hold_done;
        m_ready   = 1'b0;
        hold_left = 0;
        hold_done = 1'b0;
        forever begin
            @(negedge aclk);
            if (hold_go && !hold_done) begin
                hold_left = HOLD_CYCLES;
                hold_done = 1'b1;
            end
            if (hold_left > 0) begin
                m_ready = 1'b0;
                hold_left--;
            end else begin
                m_ready = ($urandom_range(99) >= dst_idle_pct);
            end
        end
    end

    // offer one item after random idle cycles and wait for its transfer
    task automatic send_item(segtree_tb_pkg::item_kind_e k, logic [IDX_W-1:0] idx,
                             logic [VAL_W-1:0] val,
                             logic [IDX_W-1:0] lo, logic [IDX_W-1:0] hi);
        @(negedge aclk);
        while ($urandom_range(99) < src_idle_pct) begin
            s_valid = 1'b0;
            @(negedge aclk);
        end
        s_valid      = 1'b1;
        s_kind       = k;
        s_index      = idx;
        s_value      = val;
        s_range_low  = lo;
        s_range_high = hi;
        do @(posedge aclk); while (!s_ready);
    endtask

    // random mix of updates and queries, ranges shaped toward edge cases
    task automatic send_random(int unsigned count);
        segtree_tb_pkg::item_kind_e k;
        logic [IDX_W-1:0]           idx;
        logic [IDX_W-1:0]           lo;
        logic [IDX_W-1:0]           hi;
        logic [VAL_W-1:0]           val;
        int unsigned                pick;
        int unsigned                span_end;
        repeat (count) begin
            k   = ($urandom_range(99) < 45) ? segtree_tb_pkg::ITEM_UPDATE
                                            : segtree_tb_pkg::ITEM_QUERY;
            idx = IDX_W'(($urandom_range(99) < 30) ? $urandom_range(31)
                                                   : $urandom_range(1023));
            // mostly random values, sometimes the signed extremes
            if ($urandom_range(99) < 10) begin
                case ($urandom_range(4))
                    0:       val = 32'h7FFF_FFFF;
                    1:       val = 32'h8000_0000;
                    2:       val = 32'hFFFF_FFFF;
                    3:       val = 32'h0000_0001;
                    default: val = '0;
                endcase
            end else begin
                val = $urandom();
            end
            pick = $urandom_range(99);
            if (pick < 10) begin
                // inverted range
                lo = IDX_W'($urandom_range(1023, 1));
                hi = IDX_W'($urandom_range(lo - 1, 0));
            end else if (pick < 20) begin
                // reaches the top of the array
                lo = IDX_W'(($urandom_range(99) < 50) ? 0 : $urandom_range(1023));
                hi = 1023;
            end else if (pick < 50) begin
                // short window
                lo       = IDX_W'($urandom_range(1023));
                span_end = lo + $urandom_range(15);
                hi       = IDX_W'((span_end > 1023) ? 1023 : span_end);
            end else begin
                lo = IDX_W'($urandom_range(1023));
                hi = IDX_W'($urandom_range(1023));
                if (lo > hi) begin
                    {lo, hi} = {hi, lo};
                end
            end
            send_item(k, idx, val, lo, hi);
        end
    endtask

    // stimulus and verdict
    initial begin
        aresetn      = 1'b0;
        s_valid      = 1'b0;
        s_kind       = segtree_tb_pkg::ITEM_UPDATE;
        s_index      = '0;
        s_value      = '0;
        s_range_low  = '0;
        s_range_high = '0;
        src_idle_pct = 23;
        dst_idle_pct = 76;
        hold_go      = 1'b0;
        repeat (6) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // directed: empty tree, array ends, wrapping sums, inverted ranges
        send_item(segtree_tb_pkg::ITEM_QUERY,  '1,   '1,            0,    1023);
        send_item(segtree_tb_pkg::ITEM_UPDATE, 0,    32'h7FFF_FFFF, '1,   '1);
        send_item(segtree_tb_pkg::ITEM_UPDATE, 1023, 32'h8000_0000, 0,    0);
        send_item(segtree_tb_pkg::ITEM_UPDATE, 512,  32'hFFFF_FFFF, 0,    1023);
        send_item(segtree_tb_pkg::ITEM_UPDATE, 1,    32'h0000_0001, 1023, 0);
        send_item(segtree_tb_pkg::ITEM_UPDATE, 511,  32'h7FFF_FFFF, 0,    0);
        send_item(segtree_tb_pkg::ITEM_QUERY,  0,    0,             0,    1023);
        send_item(segtree_tb_pkg::ITEM_QUERY,  0,    0,             0,    0);
        send_item(segtree_tb_pkg::ITEM_QUERY,  0,    0,             1023, 1023);
        send_item(segtree_tb_pkg::ITEM_QUERY,  0,    0,             0,    1);
        send_item(segtree_tb_pkg::ITEM_QUERY,  0,    0,             511,  512);
        send_item(segtree_tb_pkg::ITEM_QUERY,  0,    0,             5,    4);
        send_item(segtree_tb_pkg::ITEM_QUERY,  '1,   '1,            1023, 0);
        send_item(segtree_tb_pkg::ITEM_UPDATE, 0,    0,             0,    0);
        send_item(segtree_tb_pkg::ITEM_QUERY,  0,    0,             0,    1023);
        send_item(segtree_tb_pkg::ITEM_QUERY,  0,    0,             1,    1022);
        send_item(segtree_tb_pkg::ITEM_QUERY,  0,    0,             512,  1023);
        send_item(segtree_tb_pkg::ITEM_UPDATE, 700,  32'h8000_0000, 0,    0);
        send_item(segtree_tb_pkg::ITEM_QUERY,  0,    0,             700,  700);
        send_item(segtree_tb_pkg::ITEM_QUERY,  0,    0,             600,  800);

        // random traffic under three idle patterns
        send_random(430);
        src_idle_pct = 76;
        dst_idle_pct = 23;
        send_random(430);
        src_idle_pct = 0;
        dst_idle_pct = 0;
        hold_go      = 1'b1;
        send_random(440);

        @(negedge aclk);
        s_valid = 1'b0;
        while (pending_count != 0) begin
            @(posedge aclk);
        end
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (fail_count == 0) begin
            $display("PASS segment_tree_point_update_range_sum_top");
        end else begin
            $display("FAIL segment_tree_point_update_range_sum_top");
        end
        $finish;
    end

endmodule

@@ files.f @@
rtl/core/segtree_pkg.sv
rtl/core/segtree_ram.sv
rtl/core/segtree_ctrl.sv
rtl/core/segtree_dp.sv
rtl/core/segment_tree_point_update_range_sum_top.sv
tb/segtree_tb_pkg.sv
tb/segtree_range_sum_checker.sv
tb/segment_tree_point_update_range_sum_top_tb.sv
